### rtl/xml_entity_decoder_utf8_defines.svh
// ----------------------------------------------------------------------------
// XML entity decoder assertion macros
// Shared concurrent assertion forms. They compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef XML_ENTITY_DECODER_UTF8_DEFINES_SVH
`define XML_ENTITY_DECODER_UTF8_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define XED_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("xed assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define XED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("xed assertion failed");

`else

`define XED_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define XED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/xed_pkg.sv
// ----------------------------------------------------------------------------
// XML entity decoder package
// Shared types, character codes, entity name table and UTF-8 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package xed_pkg;

	// Most result bytes one input byte can cause.
	localparam int unsigned MAX_RUN = 6;
	// Default depth of the command queue between front and back.
	localparam int unsigned XED_FIFO_DEPTH = 4;

	localparam logic [20:0] CODE_MAX = 21'h10FFFF;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_X    = 8'h78;

	typedef logic [7:0] byte_t;
	typedef logic [3:0] node_t;

	// A run of up to six bytes with its length.
	typedef struct packed {
		byte_t [MAX_RUN-1:0] data;
		logic  [2:0]         len;
	} seg_t;

	// Everything one input byte produces. A count of zero is a bare end marker.
	typedef struct packed {
		byte_t [MAX_RUN-1:0] data;
		logic  [2:0]         count;
		logic                is_end;
	} cmd_t;

	// Successor in the entity name trie; zero means no match.
	function automatic node_t next_node(node_t cur, byte_t b);
		node_t nx;
		nx = 4'd0;
		case (cur)
			4'd0: begin
				if (b == "a") nx = 4'd1;
				else if (b == "l") nx = 4'd7;
				else if (b == "g") nx = 4'd9;
				else if (b == "q") nx = 4'd11;
			end
			4'd1: begin
				if (b == "m") nx = 4'd2;
				else if (b == "p") nx = 4'd4;
			end
			4'd2:  if (b == "p") nx = 4'd3;
			4'd4:  if (b == "o") nx = 4'd5;
			4'd5:  if (b == "s") nx = 4'd6;
			4'd7:  if (b == "t") nx = 4'd8;
			4'd9:  if (b == "t") nx = 4'd10;
			4'd11: if (b == "u") nx = 4'd12;
			4'd12: if (b == "o") nx = 4'd13;
			4'd13: if (b == "t") nx = 4'd14;
			default: nx = 4'd0;
		endcase
		return nx;
	endfunction

	// Character a complete entity name stands for; zero if not complete.
	function automatic byte_t node_char(node_t n);
		byte_t c;
		case (n)
			4'd3:    c = 8'h26;
			4'd6:    c = 8'h27;
			4'd8:    c = 8'h3C;
			4'd10:   c = 8'h3E;
			4'd14:   c = 8'h22;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// The '&' and the held name prefix, replayed as plain bytes.
	function automatic seg_t name_flush(node_t n);
		seg_t s;
		s = '0;
		s.data[0] = CH_AMP;
		s.len = 3'd1;
		case (n)
			4'd1:  begin s.data[1] = "a"; s.len = 3'd2; end
			4'd2:  begin s.data[1] = "a"; s.data[2] = "m"; s.len = 3'd3; end
			4'd3:  begin
				s.data[1] = "a"; s.data[2] = "m"; s.data[3] = "p"; s.len = 3'd4;
			end
			4'd4:  begin s.data[1] = "a"; s.data[2] = "p"; s.len = 3'd3; end
			4'd5:  begin
				s.data[1] = "a"; s.data[2] = "p"; s.data[3] = "o"; s.len = 3'd4;
			end
			4'd6:  begin
				s.data[1] = "a"; s.data[2] = "p"; s.data[3] = "o"; s.data[4] = "s";
				s.len = 3'd5;
			end
			4'd7:  begin s.data[1] = "l"; s.len = 3'd2; end
			4'd8:  begin s.data[1] = "l"; s.data[2] = "t"; s.len = 3'd3; end
			4'd9:  begin s.data[1] = "g"; s.len = 3'd2; end
			4'd10: begin s.data[1] = "g"; s.data[2] = "t"; s.len = 3'd3; end
			4'd11: begin s.data[1] = "q"; s.len = 3'd2; end
			4'd12: begin s.data[1] = "q"; s.data[2] = "u"; s.len = 3'd3; end
			4'd13: begin
				s.data[1] = "q"; s.data[2] = "u"; s.data[3] = "o"; s.len = 3'd4;
			end
			4'd14: begin
				s.data[1] = "q"; s.data[2] = "u"; s.data[3] = "o"; s.data[4] = "t";
				s.len = 3'd5;
			end
			default: s.len = 3'd1;
		endcase
		return s;
	endfunction

	// UTF-8 form of a code point; an empty run for zero or out-of-range values.
	function automatic seg_t utf8_encode(logic [20:0] c);
		seg_t s;
		s = '0;
		if (c == 21'd0 || c > CODE_MAX) begin
			s.len = 3'd0;
		end else if (c < 21'h80) begin
			s.data[0] = {1'b0, c[6:0]};
			s.len = 3'd1;
		end else if (c < 21'h800) begin
			s.data[0] = {3'b110, c[10:6]};
			s.data[1] = {2'b10, c[5:0]};
			s.len = 3'd2;
		end else if (c < 21'h10000) begin
			s.data[0] = {4'b1110, c[15:12]};
			s.data[1] = {2'b10, c[11:6]};
			s.data[2] = {2'b10, c[5:0]};
			s.len = 3'd3;
		end else begin
			s.data[0] = {5'b11110, c[20:18]};
			s.data[1] = {2'b10, c[17:12]};
			s.data[2] = {2'b10, c[11:6]};
			s.data[3] = {2'b10, c[5:0]};
			s.len = 3'd4;
		end
		return s;
	endfunction

	// Digit value with a valid flag in the top bit.
	function automatic logic [4:0] digit_value(byte_t b, logic hex);
		logic [4:0] d;
		d = 5'd0;
		if (b >= "0" && b <= "9")
			d = {1'b1, b[3:0]};
		else if (hex && ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")))
			d = {1'b1, 4'(b[3:0] + 4'd9)};
		return d;
	endfunction

endpackage

`default_nettype wire

### rtl/xed_front.sv
// ----------------------------------------------------------------------------
// XML entity decoder front end
// Tracks entity and numeric reference state and turns each byte into a command.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xml_entity_decoder_utf8_defines.svh"

module xed_front import xed_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  take,
	input  byte_t in_byte,
	input  logic  last_byte,
	output cmd_t  cmd,
	output logic  cmd_valid
);

	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_NAME  = 2'd1;
	localparam logic [1:0] MODE_NUM   = 2'd2;

	logic [1:0]  mode_q, mode_n;
	node_t       node_q, node_n;
	logic [20:0] code_q, code_n;
	logic        hex_q, hex_n;
	logic        first_q, first_n;
	logic        stopped_q, stopped_n;
	logic        big_q, big_n;

	node_t       nx;
	byte_t       ch;
	logic [4:0]  dig;
	logic [24:0] scaled;
	logic [24:0] prod;
	seg_t        seg1, seg2, enc;
	logic        single_en;
	byte_t       single_b;
	logic        semi_num;
	logic        code_emit;
	logic [20:0] emit_val;
	logic        emit_big;
	logic [2:0]  total;
	logic [2:0]  k;

	always_comb begin
		nx     = next_node(node_q, in_byte);
		ch     = node_char(node_q);
		dig    = digit_value(in_byte, hex_q);
		scaled = hex_q ? ({4'b0, code_q} << 4)
			: (({4'b0, code_q} << 3) + ({4'b0, code_q} << 1));
		prod   = scaled + {21'b0, dig[3:0]};
	end

	always_comb begin
		mode_n    = mode_q;
		node_n    = node_q;
		code_n    = code_q;
		hex_n     = hex_q;
		first_n   = first_q;
		stopped_n = stopped_q;
		big_n     = big_q;
		seg1      = '0;
		single_en = 1'b0;
		single_b  = in_byte;
		semi_num  = 1'b0;
		case (mode_q)
			MODE_NAME: begin
				if (node_q == 4'd0 && in_byte == CH_HASH) begin
					code_n    = '0;
					hex_n     = 1'b0;
					stopped_n = 1'b0;
					big_n     = 1'b0;
					first_n   = 1'b1;
					mode_n    = MODE_NUM;
				end else if (in_byte == CH_SEMI && ch != 8'h00) begin
					single_en = 1'b1;
					single_b  = ch;
					mode_n    = MODE_PLAIN;
					node_n    = 4'd0;
				end else if (nx != 4'd0) begin
					node_n = nx;
				end else begin
					// Unknown name: replay the prefix, then treat the byte as fresh text.
					seg1   = name_flush(node_q);
					node_n = 4'd0;
					if (in_byte == CH_AMP) begin
						mode_n = MODE_NAME;
					end else begin
						mode_n    = MODE_PLAIN;
						single_en = 1'b1;
					end
				end
			end
			MODE_NUM: begin
				if (in_byte == CH_SEMI) begin
					semi_num  = 1'b1;
					mode_n    = MODE_PLAIN;
					code_n    = '0;
					hex_n     = 1'b0;
					first_n   = 1'b0;
					stopped_n = 1'b0;
					big_n     = 1'b0;
				end else if (first_q && in_byte == CH_X) begin
					first_n = 1'b0;
					hex_n   = 1'b1;
				end else begin
					first_n = 1'b0;
					if (!stopped_q) begin
						if (!dig[4]) begin
							stopped_n = 1'b1;
						end else if (!big_q) begin
							if (prod > {4'b0, CODE_MAX})
								big_n = 1'b1;
							else
								code_n = prod[20:0];
						end
					end
				end
			end
			default: begin
				if (in_byte == CH_AMP) begin
					mode_n = MODE_NAME;
					node_n = 4'd0;
				end else begin
					mode_n    = MODE_PLAIN;
					single_en = 1'b1;
				end
			end
		endcase
	end

	// Second run: a single byte, an encoded code point or the end-of-string flush.
	always_comb begin
		emit_val  = semi_num ? code_q : code_n;
		emit_big  = semi_num ? big_q : big_n;
		code_emit = semi_num || (last_byte && mode_n == MODE_NUM);
		enc       = utf8_encode(emit_val);
		if (emit_big)
			enc.len = 3'd0;
		seg2 = '0;
		if (single_en) begin
			seg2.data[0] = single_b;
			seg2.len     = 3'd1;
		end else if (code_emit) begin
			seg2 = enc;
		end else if (last_byte && mode_n == MODE_NAME) begin
			seg2 = name_flush(node_n);
		end
		total = seg1.len + seg2.len;
	end

	always_comb begin
		cmd = '0;
		for (int i = 0; i < MAX_RUN; i++) begin
			k = 3'(i) - seg1.len;
			if (3'(i) < seg1.len)
				cmd.data[i] = seg1.data[i];
			else if (k < seg2.len)
				cmd.data[i] = seg2.data[k];
		end
		cmd.count = total;
		cmd.is_end = last_byte;
		cmd_valid = take && (total != 3'd0 || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PLAIN;
			node_q    <= 4'd0;
			code_q    <= '0;
			hex_q     <= 1'b0;
			first_q   <= 1'b0;
			stopped_q <= 1'b0;
			big_q     <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				mode_q    <= MODE_PLAIN;
				node_q    <= 4'd0;
				code_q    <= '0;
				hex_q     <= 1'b0;
				first_q   <= 1'b0;
				stopped_q <= 1'b0;
				big_q     <= 1'b0;
			end else begin
				mode_q    <= mode_n;
				node_q    <= node_n;
				code_q    <= code_n;
				hex_q     <= hex_n;
				first_q   <= first_n;
				stopped_q <= stopped_n;
				big_q     <= big_n;
			end
		end
	end

	`XED_ASSERT_NEXT(a_end_clears_state, clk, arst_n, take && last_byte, mode_q == MODE_PLAIN && node_q == 4'd0 && code_q == 21'd0)
	`XED_ASSERT_IMPLY(a_null_only_at_end, clk, arst_n, cmd_valid && cmd.count == 3'd0, cmd.is_end)
	`XED_ASSERT_IMPLY(a_run_fits, clk, arst_n, cmd_valid, cmd.count <= 3'd6)

endmodule

`default_nettype wire

### rtl/xed_fifo.sv
// ----------------------------------------------------------------------------
// XML entity decoder command queue
// Small register queue of commands between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module xed_fifo import xed_pkg::*; #(
	parameter int unsigned DEPTH = XED_FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t rdata,
	output logic empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

### rtl/xed_back.sv
// ----------------------------------------------------------------------------
// XML entity decoder back end
// Plays out one queued command as a run of result bytes, one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xml_entity_decoder_utf8_defines.svh"

module xed_back import xed_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  fifo_data,
	input  logic  fifo_empty,
	output logic  fifo_pop,
	input  logic  pop,
	output logic  empty,
	output byte_t out_byte,
	output logic  byte_valid,
	output logic  string_end,
	output logic  run_last
);

	cmd_t       cur_q;
	logic       cur_valid_q;
	logic [2:0] idx_q;
	logic       at_last;
	logic       finish;

	assign at_last  = (cur_q.count == 3'd0) || (idx_q == cur_q.count - 3'd1);
	assign finish   = cur_valid_q && pop && at_last;
	assign fifo_pop = (!cur_valid_q || finish) && !fifo_empty;

	assign empty      = !cur_valid_q;
	assign byte_valid = (cur_q.count != 3'd0);
	assign out_byte   = byte_valid ? cur_q.data[idx_q] : 8'h00;
	assign run_last   = at_last;
	assign string_end = at_last && cur_q.is_end;

	always_ff @(posedge clk) begin
		if (fifo_pop)
			cur_q <= fifo_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else if (fifo_pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= 3'd0;
		end else if (finish) begin
			cur_valid_q <= 1'b0;
		end else if (cur_valid_q && pop) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	`XED_ASSERT_IMPLY(a_idx_in_run, clk, arst_n, cur_valid_q && cur_q.count != 3'd0, idx_q < cur_q.count)
	`XED_ASSERT_NEXT(a_hold_when_stalled, clk, arst_n, cur_valid_q && !pop, cur_valid_q && $stable(idx_q))

endmodule

`default_nettype wire

### rtl/xml_entity_decoder_utf8.sv
// ----------------------------------------------------------------------------
// XML entity decoder with UTF-8 output
// Decodes named entities and numeric character references in a byte stream.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                  Payload
// input     in         push / full                in_byte, last_byte
// result    out        empty / pop                out_byte, byte_valid,
//                                                 string_end, run_last
//
// One input transaction is taken per cycle while the command queue has room.
// Each input byte queues at most one command of zero to six result bytes;
// the back end plays it out at one result per cycle while pop is high, so
// the result port sets the sustained rate. A byte's first result shows once
// the back end loads its command. When pop is held low the queue of FIFO_DEPTH
// commands fills and full rises. Reset clears the decoder state and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module xml_entity_decoder_utf8 import xed_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = XED_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       last_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       string_end,
	output logic       run_last
);

	// Front end: the decoder state advances on every accepted transaction.
	logic take;
	cmd_t front_cmd;
	logic front_cmd_valid;

	// Command queue between the two halves.
	logic fifo_full;
	logic fifo_empty;
	logic fifo_pop;
	cmd_t fifo_data;

	assign full = fifo_full;
	assign take = push && !fifo_full;

	xed_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.cmd       (front_cmd),
		.cmd_valid (front_cmd_valid)
	);

	// Bytes that yield nothing and are not the end of a string push nothing.
	xed_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_cmd_valid),
		.wdata  (front_cmd),
		.full   (fifo_full),
		.pop    (fifo_pop),
		.rdata  (fifo_data),
		.empty  (fifo_empty)
	);

	// Back end: the command it holds acts as the output register.
	xed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_data  (fifo_data),
		.fifo_empty (fifo_empty),
		.fifo_pop   (fifo_pop),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.string_end (string_end),
		.run_last   (run_last)
	);

endmodule

`default_nettype wire
